>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Needs nothing else; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/grls_pkg.sv
// Package for the GUID record list search: record codes, status codes,
// configuration register indexes and the result type. Depends on nothing.
package grls_pkg;

	localparam logic [15:0] TYPE_GUID_EXT = 16'h0004;
	localparam logic [15:0] TYPE_END      = 16'hFFFF;
	localparam logic [15:0] HDR_BYTES     = 16'd8;
	localparam logic [15:0] GUID_HDR      = 16'd24;
	localparam logic [15:0] GUID_FIRST    = 16'd8;
	localparam logic [15:0] GUID_LAST     = 16'd23;

	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_END     = 2'd1;
	localparam logic [1:0] ST_CORRUPT = 2'd2;

	localparam logic [1:0] CFG_LIST_LENGTH = 2'd0;
	localparam logic [1:0] CFG_GUID_LOW    = 2'd1;
	localparam logic [1:0] CFG_GUID_HIGH   = 2'd2;

	typedef struct packed {
		logic [1:0]  search_status;
		logic [31:0] payload_offset;
		logic [15:0] payload_size;
	} result_t;

endpackage

>>> hw/rtl/grls_cfg.sv
// Configuration registers of the GUID record list search.
// Depends on grls_pkg for the register indexes.
module grls_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic [31:0] list_length,
	output logic [63:0] target_guid_low,
	output logic [63:0] target_guid_high
);

	logic [31:0] list_length_q;
	logic [63:0] guid_low_q;
	logic [63:0] guid_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q <= '0;
			guid_low_q    <= '0;
			guid_high_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				grls_pkg::CFG_LIST_LENGTH: list_length_q <= cfg_data[31:0];
				grls_pkg::CFG_GUID_LOW:    guid_low_q    <= cfg_data;
				grls_pkg::CFG_GUID_HIGH:   guid_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign list_length      = list_length_q;
	assign target_guid_low  = guid_low_q;
	assign target_guid_high = guid_high_q;

endmodule

>>> hw/rtl/grls_walk.sv
// Input register and record walker of the GUID record list search: decodes
// headers, compares the GUID name and decides the result. Depends on grls_pkg.
module grls_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        list_byte,
	input  logic              first_byte,
	input  logic [31:0]       list_length,
	input  logic [63:0]       target_guid_low,
	input  logic [63:0]       target_guid_high,
	input  logic              out_free,
	output logic              res_load,
	output grls_pkg::result_t res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;

	logic [31:0] rs_q;
	logic [15:0] bir_q;
	logic [15:0] type_q;
	logic [15:0] len_q;
	logic        match_q;
	logic        done_q;

	logic [31:0] eff_rs;
	logic [15:0] eff_bir;
	logic [15:0] eff_type;
	logic [15:0] eff_len;
	logic        eff_match;
	logic        eff_done;

	logic [31:0] nxt_rs;
	logic [15:0] nxt_bir;
	logic [15:0] nxt_type;
	logic [15:0] nxt_len;
	logic        nxt_match;
	logic        emit;
	logic        stop;

	logic [16:0]  i_inc;
	logic [15:0]  len_full;
	logic [15:0]  type_full;
	logic [32:0]  left;
	logic         len_bad;
	logic [4:0]   k5;
	logic [3:0]   k;
	logic [127:0] guid;
	logic [7:0]   want;
	logic         in_name;
	logic         match_n;
	logic         proc;
	logic         accept;

	function automatic logic no_room(input logic [31:0] start, input logic [31:0] ll);
		no_room = ({1'b0, start} + {17'b0, grls_pkg::HDR_BYTES}) > {1'b0, ll};
	endfunction

	assign guid      = {target_guid_high, target_guid_low};
	assign type_full = {byte_s1, eff_type[7:0]};
	assign len_full  = {byte_s1, eff_len[7:0]};
	assign left      = {1'b0, list_length} - {1'b0, eff_rs};
	assign len_bad   = (len_full < grls_pkg::HDR_BYTES)
		|| (!left[32] && ({16'b0, len_full} > left[31:0]));
	assign k5        = eff_bir[4:0] - 5'd8;
	assign k         = k5[3:0];
	assign want      = guid[{k, 3'b000} +: 8];
	assign in_name   = (eff_type == grls_pkg::TYPE_GUID_EXT)
		&& (eff_bir >= grls_pkg::GUID_FIRST) && (eff_bir <= grls_pkg::GUID_LAST);
	assign match_n   = eff_match && (want == byte_s1);
	assign i_inc     = {1'b0, eff_bir} + 17'd1;

	always_comb begin
		eff_rs    = rs_q;
		eff_bir   = bir_q;
		eff_type  = type_q;
		eff_len   = len_q;
		eff_match = match_q;
		eff_done  = done_q;
		if (first_s1) begin
			eff_rs    = '0;
			eff_bir   = '0;
			eff_type  = '0;
			eff_len   = '0;
			eff_match = 1'b1;
			eff_done  = 1'b0;
		end
	end

	always_comb begin
		nxt_rs    = eff_rs;
		nxt_bir   = eff_bir;
		nxt_type  = eff_type;
		nxt_len   = eff_len;
		nxt_match = eff_match;
		emit      = 1'b0;
		stop      = 1'b0;
		res       = '0;
		if (!eff_done) begin
			if (eff_bir == 16'd0) begin
				nxt_type = {8'b0, byte_s1};
				if (no_room(eff_rs, list_length)) begin
					emit              = 1'b1;
					res.search_status = grls_pkg::ST_CORRUPT;
				end
			end else if (eff_bir == 16'd1) begin
				nxt_type = type_full;
				if (type_full == grls_pkg::TYPE_END) begin
					emit              = 1'b1;
					res.search_status = grls_pkg::ST_END;
				end
			end else if (eff_bir == 16'd2) begin
				nxt_len = {8'b0, byte_s1};
			end else if (eff_bir == 16'd3) begin
				nxt_len = len_full;
				if (len_bad || ((eff_type == grls_pkg::TYPE_GUID_EXT)
						&& (len_full < grls_pkg::GUID_HDR))) begin
					emit              = 1'b1;
					res.search_status = grls_pkg::ST_CORRUPT;
				end
			end else if (in_name) begin
				nxt_match = match_n;
				if ((eff_bir == grls_pkg::GUID_LAST) && match_n) begin
					emit               = 1'b1;
					res.search_status  = grls_pkg::ST_FOUND;
					res.payload_offset = eff_rs + {16'b0, grls_pkg::GUID_HDR};
					res.payload_size   = eff_len - grls_pkg::GUID_HDR;
				end
			end
			stop = emit;
			if (!stop) begin
				if ((i_inc >= 17'd4) && (i_inc >= {1'b0, nxt_len})) begin
					nxt_rs    = eff_rs + {16'b0, nxt_len};
					nxt_bir   = '0;
					nxt_match = 1'b1;
					if (no_room(eff_rs + {16'b0, nxt_len}, list_length)) begin
						emit              = 1'b1;
						res.search_status = grls_pkg::ST_CORRUPT;
					end
				end else begin
					nxt_bir = i_inc[15:0];
				end
			end
		end
	end

	assign proc     = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !proc;
	assign accept   = in_valid && !in_stall;
	assign res_load = proc && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= list_byte;
			first_s1 <= first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q    <= '0;
			bir_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			match_q <= 1'b1;
			done_q  <= 1'b1;
		end else if (proc) begin
			rs_q    <= nxt_rs;
			bir_q   <= nxt_bir;
			type_q  <= nxt_type;
			len_q   <= nxt_len;
			match_q <= nxt_match;
			done_q  <= eff_done || emit;
		end
	end

endmodule

>>> hw/rtl/grls_out.sv
// Result register of the GUID record list search, holding one result until
// the downstream side takes it. Depends on grls_pkg for the result type.
module grls_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_load,
	input  grls_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        search_status,
	output logic [31:0]       payload_offset,
	output logic [15:0]       payload_size
);

	logic              valid_q;
	grls_pkg::result_t res_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid      = valid_q;
	assign search_status  = res_q.search_status;
	assign payload_offset = res_q.payload_offset;
	assign payload_size   = res_q.payload_size;

endmodule

>>> hw/rtl/guid_record_list_search_top.sv
// Top level of the GUID record list search: configuration, walker and result
// register. Depends on grls_pkg, grls_cfg, grls_walk and grls_out.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   in      | in_valid / in_stall   | list_byte, first_byte
//   out     | out_valid / out_stall | search_status, payload_offset, payload_size
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; a byte's result is offered
// through the input register and the result register.
// Reset clears the walker to idle; bytes are ignored until a first byte.
// A byte that yields a result waits in the input register while the previous
// result is stalled; bytes that yield nothing pass on regardless.
module guid_record_list_search_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  list_byte,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  search_status,
	output logic [31:0] payload_offset,
	output logic [15:0] payload_size,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [31:0]       list_length;
	logic [63:0]       target_guid_low;
	logic [63:0]       target_guid_high;
	logic              out_free;
	logic              res_load;
	grls_pkg::result_t res;

	grls_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.list_length      (list_length),
		.target_guid_low  (target_guid_low),
		.target_guid_high (target_guid_high)
	);

	grls_walk u_walk (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.list_byte        (list_byte),
		.first_byte       (first_byte),
		.list_length      (list_length),
		.target_guid_low  (target_guid_low),
		.target_guid_high (target_guid_high),
		.out_free         (out_free),
		.res_load         (res_load),
		.res              (res)
	);

	grls_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.res_load       (res_load),
		.res            (res),
		.out_free       (out_free),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.search_status  (search_status),
		.payload_offset (payload_offset),
		.payload_size   (payload_size)
	);

endmodule

>>> hw/rtl/grls_checker.sv
// Port-level checks of the GUID record list search, bound to the top level.
// Depends on grls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module grls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  search_status,
	input logic [31:0] payload_offset,
	input logic [15:0] payload_size
);

	// A stalled result transaction stays offered and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(search_status) && $stable(payload_offset)
		&& $stable(payload_size), "stalled result changed")

	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid,
		search_status == grls_pkg::ST_FOUND || search_status == grls_pkg::ST_END
		|| search_status == grls_pkg::ST_CORRUPT, "undefined search status")

	`ASSERT_IMPLIES(a_zero_unless_found, clk, arst_n,
		out_valid && search_status != grls_pkg::ST_FOUND,
		payload_offset == 32'd0 && payload_size == 16'd0, "payload set without a match")

	// A match lies past a full GUID header inside the list.
	`ASSERT_IMPLIES(a_found_offset, clk, arst_n,
		out_valid && search_status == grls_pkg::ST_FOUND,
		payload_offset >= {16'b0, grls_pkg::GUID_HDR}, "payload offset inside header")

endmodule

bind guid_record_list_search_top grls_checker u_grls_checker (.*);
